[hdl/ssfc_pkg.sv]
`default_nettype none
package ssfc_pkg;

    // receive buffer size in bytes
    localparam int MAX_FRAME = 256;
    localparam int IDX_W     = $clog2(MAX_FRAME + 2);
    localparam int LEN_W     = 16;
    localparam int SUM_W     = LEN_W + 1;

    localparam logic [7:0]  HDR_A    = 8'hff;
    localparam logic [7:0]  HDR_B    = 8'hfd;
    localparam logic [15:0] CRC_POLY = 16'h8005;

    // item kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  REG_RESPONSE_MODE = 2'd0;
    localparam logic [1:0]  REG_DATA_BYTES    = 2'd1;

    // response modes
    localparam logic MODE_WRITE_ACK = 1'b0;
    localparam logic MODE_READ      = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        header_bad;
        logic        crc_bad;
        logic        length_bad;
        logic [6:0]  servo_error;
        logic [31:0] read_data;
        logic        data_valid;
    } t_out_item;

    // frame verdict from the tracker
    typedef struct packed {
        logic        header_bad;
        logic        crc_bad;
        logic        length_bad;
        logic [7:0]  status_byte;
        logic [31:0] data_capture;
    } t_frame_status;

    // one byte step of crc-16, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/ssfc_tracker.sv]
`default_nettype none
module ssfc_tracker
    import ssfc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_clear,
    input  wire logic [2:0]    i_data_bytes,
    output t_frame_status      o_status
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_crc, n_crc;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_hdr_ok, n_hdr_ok;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic [7:0]       r_status, n_status;
    logic [31:0]      r_data, n_data;

    logic [SUM_W-1:0] w_idx_x;
    logic [SUM_W-1:0] w_len_x;
    logic [SUM_W-1:0] w_total;
    logic [2:0]       w_nbytes;
    logic [1:0]       w_off;

    assign w_idx_x  = SUM_W'(r_idx);
    assign w_len_x  = SUM_W'(r_len);
    assign w_total  = w_len_x + SUM_W'(7);
    assign w_nbytes = (i_data_bytes > 3'd4) ? 3'd4 : i_data_bytes;
    assign w_off    = 2'(r_idx - IDX_W'(9));

    always_comb begin
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_len    = r_len;
        n_hdr_ok = r_hdr_ok;
        n_rx_crc = r_rx_crc;
        n_status = r_status;
        n_data   = r_data;
        if (i_clear) begin
            n_idx    = '0;
            n_crc    = '0;
            n_len    = '0;
            n_hdr_ok = 1'b1;
            n_rx_crc = '0;
            n_status = '0;
            n_data   = '0;
        end else if (i_take) begin
            if (r_idx >= IDX_W'(MAX_FRAME)) begin
                // buffer full, byte dropped
                n_idx = IDX_W'(MAX_FRAME + 1);
            end else begin
                if (r_idx < IDX_W'(2) && i_byte != HDR_A) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_idx == IDX_W'(2) && i_byte != HDR_B) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_idx == IDX_W'(5)) begin
                    n_len[7:0] = i_byte;
                end
                if (r_idx == IDX_W'(6)) begin
                    n_len[15:8] = i_byte;
                end
                if (r_idx < IDX_W'(7) || w_idx_x < w_len_x + SUM_W'(5)) begin
                    n_crc = crc_byte(r_crc, i_byte);
                end
                if (r_idx >= IDX_W'(7)) begin
                    if (w_idx_x == w_len_x + SUM_W'(4)) begin
                        n_status = i_byte;
                    end
                    if (w_idx_x == w_len_x + SUM_W'(5)) begin
                        n_rx_crc[7:0] = i_byte;
                    end
                    if (w_idx_x == w_len_x + SUM_W'(6)) begin
                        n_rx_crc[15:8] = i_byte;
                    end
                    if (r_idx >= IDX_W'(9) && w_idx_x < SUM_W'(9) + SUM_W'(w_nbytes)
                            && w_idx_x < w_len_x + SUM_W'(5)) begin
                        case (w_off)
                            2'd0:    n_data[7:0]   = r_data[7:0]   | i_byte;
                            2'd1:    n_data[15:8]  = r_data[15:8]  | i_byte;
                            2'd2:    n_data[23:16] = r_data[23:16] | i_byte;
                            default: n_data[31:24] = r_data[31:24] | i_byte;
                        endcase
                    end
                end
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_crc    <= '0;
            r_len    <= '0;
            r_hdr_ok <= 1'b1;
            r_rx_crc <= '0;
            r_status <= '0;
            r_data   <= '0;
        end else begin
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_hdr_ok <= n_hdr_ok;
            r_rx_crc <= n_rx_crc;
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    always_comb begin
        o_status.header_bad   = !r_hdr_ok || r_idx < IDX_W'(3);
        o_status.crc_bad      = r_len < LEN_W'(3) || w_idx_x < w_total || r_crc != r_rx_crc;
        o_status.length_bad   = r_len < LEN_W'(3) || w_idx_x != w_total
                                || w_total > SUM_W'(MAX_FRAME)
                                || r_idx > IDX_W'(MAX_FRAME);
        o_status.status_byte  = r_status;
        o_status.data_capture = r_data;
    end

endmodule
`default_nettype wire

[hdl/servo_status_frame_checker.sv]
// a timeout beat passes through the input register, then the result register, and its result
//   beat shows from the result register; byte beats give no result
// throughput: one beat per cycle while the input side does not stall; the tracker's crc byte step is combinational
// the input side stalls only while a timeout waits behind a stalled result
// reset (synchronous, active low) clears the frame state, empties both registers
//   and sets response_mode to write acknowledge and data_bytes to 1
`default_nettype none
module servo_status_frame_checker
    import ssfc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input beats
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    // result beats
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [2:0]           i_cfg_data
);

    // configuration registers
    logic       r_response_mode;
    logic [2:0] r_data_bytes;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item w_result;

    logic          w_advance;
    logic          w_take;
    logic          w_clear;
    t_frame_status w_status;

    // config is always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_mode <= MODE_WRITE_ACK;
            r_data_bytes    <= 3'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RESPONSE_MODE: r_response_mode <= i_cfg_data[0];
                REG_DATA_BYTES:    r_data_bytes    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // byte beats always move on; a timeout needs room in the result register
    assign w_advance  = (r_in.kind == KIND_BYTE) || !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_take     = r_in_valid && w_advance && (r_in.kind == KIND_BYTE);
    assign w_clear    = r_in_valid && w_advance && (r_in.kind == KIND_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // per-frame header, length and crc tracking
    ssfc_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_byte       (r_in.rx_byte),
        .i_clear      (w_clear),
        .i_data_bytes (r_data_bytes),
        .o_status     (w_status)
    );

    // mode picks servo error bits or captured data
    always_comb begin
        w_result.header_bad = w_status.header_bad;
        w_result.crc_bad    = w_status.crc_bad;
        w_result.length_bad = w_status.length_bad;
        if (r_response_mode == MODE_WRITE_ACK) begin
            w_result.servo_error = w_status.status_byte[7] ? w_status.status_byte[6:0] : 7'd0;
            w_result.read_data   = '0;
            w_result.data_valid  = 1'b0;
        end else begin
            w_result.servo_error = 7'd0;
            w_result.read_data   = w_status.data_capture;
            w_result.data_valid  = !w_status.header_bad && !w_status.crc_bad
                                   && !w_status.length_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_clear) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

[hdl/ssfc_checker.sv]
`default_nettype none
module ssfc_assertions
    import ssfc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      o_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item o_out_item
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // data only marked good on a clean frame
    a_valid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.data_valid |->
            !o_out_item.header_bad && !o_out_item.crc_bad && !o_out_item.length_bad)
        else $error("data_valid with an error flag");

    // read mode carries no servo error bits
    a_valid_no_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.data_valid |-> o_out_item.servo_error == 7'd0)
        else $error("servo_error in read mode");

    // servo error bits only in write mode, where data is zero
    a_servo_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.servo_error != 7'd0 |->
            o_out_item.read_data == 32'd0 && !o_out_item.data_valid)
        else $error("servo_error together with read data");

endmodule

bind servo_status_frame_checker ssfc_assertions u_ssfc_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
